// ===== sv/lcms_pkg.sv =====
`timescale 1ns / 1ps

package lcms_pkg;

  // Cube geometry.
  localparam int LEVELS  = 4;
  localparam int COLUMNS = 16;
  localparam int CELLS   = LEVELS * COLUMNS;

  // Derived widths.
  localparam int POS_W   = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int LIDX_W  = $clog2(LEVELS);
  localparam int LVL_W   = $clog2(LEVELS + 1);

  // Widths of the word fields.
  localparam int ACTION_W    = 2;
  localparam int IN_LEVEL_W  = 2;
  localparam int IN_COLUMN_W = 4;
  localparam int ENABLE_W    = 4;
  localparam int ADDR_W      = 3;
  localparam int DWELL_W     = 16;

  // Dwell time after reset.
  localparam logic [DWELL_W-1:0] DWELL_RESET = DWELL_W'(1200);

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // Index of the lowest set bit of a frame vector.
  function automatic logic [POS_W-1:0] lowest_set(input logic [CELLS-1:0] v);
    logic [POS_W-1:0] idx;
    idx = '0;
    for (int i = CELLS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = POS_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== sv/lcms_ifs.sv =====
`timescale 1ns / 1ps

// Input word: a tick, a write of one LED bit, or a frame clear.
interface lcms_item_if;
  logic                                valid;
  logic                                ready;
  logic [lcms_pkg::ACTION_W-1:0]       action;
  logic [lcms_pkg::IN_LEVEL_W-1:0]     led_level;
  logic [lcms_pkg::IN_COLUMN_W-1:0]    led_column;
  logic                                led_on;

  modport source (output valid, action, led_level, led_column, led_on, input ready);
  modport sink   (input valid, action, led_level, led_column, led_on, output ready);
endinterface

// Result word: the pin states after one input word.
interface lcms_result_if;
  logic                                valid;
  logic                                ready;
  logic [lcms_pkg::ENABLE_W-1:0]       level_enable_n;
  logic                                bank_select;
  logic [lcms_pkg::ADDR_W-1:0]         column_address;
  logic                                frame_empty;

  modport source (output valid, level_enable_n, bank_select, column_address, frame_empty,
                  input ready);
  modport sink   (input valid, level_enable_n, bank_select, column_address, frame_empty,
                  output ready);
endinterface

// ===== sv/led_cube_multiplex_scanner.sv =====
`timescale 1ns / 1ps

// Scan driver for a multiplexed LED cube. The block holds an on/off frame of
// LEVELS x COLUMNS bits and, on each tick word, scans it one lit LED at a time,
// holding each lit LED for dwell_ticks ticks (zero acts as one). Write and clear
// words only change the frame. Every input word produces exactly one result
// word carrying the pin states after it: active-low level enables, the decoder
// bank select, the 3-bit column address and an empty-frame flag. A word passes
// through the input register and then the result register, and one word is
// taken every cycle while the result register is not stalled; the state update,
// including the next-lit search (a priority encode over the frame from the start
// position and one over the whole frame), sits between the two registers. A
// stalled result register holds the input register and thus the input channel.
module led_cube_multiplex_scanner (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lcms_pkg::DWELL_W-1:0]    cfg_wdata,
  lcms_item_if.sink                       item,
  lcms_result_if.source                   result
);

  // Configuration.
  logic [lcms_pkg::DWELL_W-1:0]     dwell_ticks;

  // Input register.
  logic                             s1_valid;
  logic [lcms_pkg::ACTION_W-1:0]    s1_action;
  logic [lcms_pkg::IN_LEVEL_W-1:0]  s1_level;
  logic [lcms_pkg::IN_COLUMN_W-1:0] s1_column;
  logic                             s1_on;
  logic                             s1_advance;
  logic                             s1_fire;

  // Scanner state.
  logic [lcms_pkg::CELLS-1:0]       frame_bits, frame_bits_next;
  logic [lcms_pkg::POS_W-1:0]       scan_position, scan_position_next;
  logic [lcms_pkg::DWELL_W-1:0]     dwell_count, dwell_count_next;
  logic                             showing, showing_next;
  logic [lcms_pkg::LVL_W-1:0]       active_level, active_level_next;
  logic [lcms_pkg::LEVELS-1:0]      level_en_n, level_en_n_next;
  logic                             bank, bank_next;
  logic [lcms_pkg::ADDR_W-1:0]      addr, addr_next;

  // Search signals.
  logic [lcms_pkg::POS_W-1:0]       start_pos;
  logic [lcms_pkg::CELLS-1:0]       upper_mask;
  logic [lcms_pkg::CELLS-1:0]       upper_bits;
  logic [lcms_pkg::POS_W-1:0]       found_pos;
  logic [lcms_pkg::LVL_W-1:0]       found_level;
  logic [lcms_pkg::COL_W-1:0]       found_column;
  logic [lcms_pkg::POS_W-1:0]       write_pos;
  logic                             dwell_more;
  logic [lcms_pkg::ENABLE_W-1:0]    enable_out;

  // Output register.
  logic                             out_valid;

  assign s1_advance = !out_valid || result.ready;
  assign s1_fire    = s1_valid && s1_advance;
  assign item.ready = !s1_valid || s1_advance;

  // Dwell register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ticks <= lcms_pkg::DWELL_RESET;
    end else if (cfg_we) begin
      dwell_ticks <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      s1_action <= item.action;
      s1_level  <= item.led_level;
      s1_column <= item.led_column;
      s1_on     <= item.led_on;
    end
  end

  // Start of the search: after the shown LED, or at it when nothing is shown.
  always_comb begin
    if (showing) begin
      start_pos = (scan_position == lcms_pkg::POS_W'(lcms_pkg::CELLS - 1)) ?
                  '0 : scan_position + 1'b1;
    end else begin
      start_pos = scan_position;
    end
    for (int i = 0; i < lcms_pkg::CELLS; i++) begin
      upper_mask[i] = (lcms_pkg::POS_W'(i) >= start_pos);
    end
  end

  // Wrapping search for the next lit LED.
  assign upper_bits   = frame_bits & upper_mask;
  assign found_pos    = (upper_bits != '0) ? lcms_pkg::lowest_set(upper_bits) :
                                             lcms_pkg::lowest_set(frame_bits);
  assign found_level  = lcms_pkg::LVL_W'(found_pos / lcms_pkg::COLUMNS);
  assign found_column = lcms_pkg::COL_W'(found_pos % lcms_pkg::COLUMNS);
  assign write_pos    = lcms_pkg::POS_W'(int'(s1_level) * lcms_pkg::COLUMNS +
                                         int'(s1_column));
  assign dwell_more   = showing &&
                        (({1'b0, dwell_count} + 1'b1) < {1'b0, dwell_ticks});

  // State update for the word in the input register.
  always_comb begin
    frame_bits_next    = frame_bits;
    scan_position_next = scan_position;
    dwell_count_next   = dwell_count;
    showing_next       = showing;
    active_level_next  = active_level;
    level_en_n_next    = level_en_n;
    bank_next          = bank;
    addr_next          = addr;
    if (s1_fire) begin
      unique case (s1_action)
        lcms_pkg::ACT_TICK: begin
          if (frame_bits == '0) begin
            showing_next     = 1'b0;
            dwell_count_next = '0;
          end else if (dwell_more) begin
            dwell_count_next = dwell_count + 1'b1;
          end else begin
            if (active_level != found_level) begin
              if (active_level < lcms_pkg::LVL_W'(lcms_pkg::LEVELS)) begin
                level_en_n_next[active_level[lcms_pkg::LIDX_W-1:0]] = 1'b1;
              end
              level_en_n_next[found_level[lcms_pkg::LIDX_W-1:0]] = 1'b0;
              active_level_next = found_level;
            end
            bank_next          = !found_column[lcms_pkg::COL_W-1];
            addr_next          = found_column[lcms_pkg::ADDR_W-1:0];
            scan_position_next = found_pos;
            dwell_count_next   = '0;
            showing_next       = 1'b1;
          end
        end
        lcms_pkg::ACT_WRITE: begin
          if (int'(s1_level) < lcms_pkg::LEVELS) begin
            frame_bits_next[write_pos] = s1_on;
          end
        end
        lcms_pkg::ACT_CLEAR: begin
          frame_bits_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Scanner state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits    <= '0;
      scan_position <= '0;
      dwell_count   <= '0;
      showing       <= 1'b0;
      active_level  <= lcms_pkg::LVL_W'(lcms_pkg::LEVELS);
      level_en_n    <= '1;
      bank          <= 1'b1;
      addr          <= '0;
    end else begin
      frame_bits    <= frame_bits_next;
      scan_position <= scan_position_next;
      dwell_count   <= dwell_count_next;
      showing       <= showing_next;
      active_level  <= active_level_next;
      level_en_n    <= level_en_n_next;
      bank          <= bank_next;
      addr          <= addr_next;
    end
  end

  // Only the lowest four level enables reach the pins.
  always_comb begin
    enable_out = '0;
    for (int i = 0; i < lcms_pkg::ENABLE_W; i++) begin
      if (i < lcms_pkg::LEVELS) begin
        enable_out[i] = level_en_n_next[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire) begin
      result.level_enable_n <= enable_out;
      result.bank_select    <= bank_next;
      result.column_address <= addr_next;
      result.frame_empty    <= (frame_bits_next == '0);
    end
  end

  assign result.valid = out_valid;

endmodule

// ===== bench/led_cube_multiplex_scanner_test.sv =====
`timescale 1ns / 1ps

module led_cube_multiplex_scanner_test;

  // Action 3 has no meaning; the block must report the pins unchanged.
  localparam logic [lcms_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [lcms_pkg::ACTION_W-1:0]    action;
    logic [lcms_pkg::IN_LEVEL_W-1:0]  level;
    logic [lcms_pkg::IN_COLUMN_W-1:0] column;
    logic                             on;
  } led_word_t;

  typedef struct packed {
    logic [lcms_pkg::ENABLE_W-1:0] enable_n;
    logic                          bank;
    logic [lcms_pkg::ADDR_W-1:0]   addr;
    logic                          empty;
  } pin_state_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [lcms_pkg::DWELL_W-1:0] cfg_wdata;

  lcms_item_if   item_bus ();
  lcms_result_if result_bus ();

  led_cube_multiplex_scanner dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_bus),
    .result    (result_bus)
  );

  // Words waiting to be sent and pin states waiting to come back.
  led_word_t  pending_words[$];
  pin_state_t expected_pins[$];
  int         fail_count = 0;

  // Scanner state as the testbench tracks it.
  logic [lcms_pkg::CELLS-1:0]    lit_map;
  int                            scan_pos;
  int                            dwell_cnt;
  logic                          showing;
  int                            active_lvl;
  logic [lcms_pkg::ENABLE_W-1:0] pin_enable_n;
  logic                          pin_bank;
  logic [lcms_pkg::ADDR_W-1:0]   pin_addr;
  logic [lcms_pkg::DWELL_W-1:0]  dwell_ticks;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one word to the tracked state and returns the pins it reports.
  function automatic pin_state_t step_scan(led_word_t w);
    pin_state_t p;
    int start_pos;
    int pos;
    int lvl;
    int col;
    logic found;
    case (w.action)
      lcms_pkg::ACT_TICK: begin
        if (lit_map == '0) begin
          showing = 1'b0;
          dwell_cnt = 0;
        end else if (showing && dwell_cnt + 1 < int'(dwell_ticks)) begin
          dwell_cnt++;
        end else begin
          // Search for the next lit LED, wrapping around the frame.
          start_pos = showing ? scan_pos + 1 : scan_pos;
          found = 1'b0;
          for (int i = 0; i < lcms_pkg::CELLS; i++) begin
            pos = (start_pos + i) % lcms_pkg::CELLS;
            if (!found && lit_map[pos]) begin
              found = 1'b1;
              lvl = pos / lcms_pkg::COLUMNS;
              col = pos % lcms_pkg::COLUMNS;
              if (active_lvl != lvl) begin
                if (active_lvl < lcms_pkg::LEVELS) pin_enable_n[active_lvl] = 1'b1;
                pin_enable_n[lvl] = 1'b0;
                active_lvl = lvl;
              end
              pin_bank = (col < 8);
              pin_addr = col[lcms_pkg::ADDR_W-1:0];
              scan_pos = pos;
            end
          end
          dwell_cnt = 0;
          showing = 1'b1;
        end
      end
      lcms_pkg::ACT_WRITE: begin
        if (int'(w.level) < lcms_pkg::LEVELS)
          lit_map[int'(w.level) * lcms_pkg::COLUMNS + int'(w.column)] = w.on;
      end
      lcms_pkg::ACT_CLEAR: begin
        lit_map = '0;
      end
      default: begin
      end
    endcase
    p.enable_n = pin_enable_n;
    p.bank = pin_bank;
    p.addr = pin_addr;
    p.empty = (lit_map == '0);
    return p;
  endfunction

  function automatic led_word_t mk_word(logic [lcms_pkg::ACTION_W-1:0] action, int level,
                                        int column, logic on);
    led_word_t w;
    w.action = action;
    w.level = level[lcms_pkg::IN_LEVEL_W-1:0];
    w.column = column[lcms_pkg::IN_COLUMN_W-1:0];
    w.on = on;
    return w;
  endfunction

  // Driver: sends queued words in bursts with random gaps in between.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    led_word_t w;
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else if (!item_bus.valid || item_bus.ready) begin
      if (gap_left > 0 || pending_words.size() == 0) begin
        if (gap_left > 0) gap_left--;
        item_bus.valid <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        item_bus.valid <= 1'b1;
        item_bus.action <= w.action;
        item_bus.led_level <= w.level;
        item_bus.led_column <= w.column;
        item_bus.led_on <= w.on;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Each accepted word is run through the tracked state right away.
  always @(posedge clk) begin
    led_word_t w;
    if (!rst && item_bus.valid && item_bus.ready) begin
      w.action = item_bus.action;
      w.level = item_bus.led_level;
      w.column = item_bus.led_column;
      w.on = item_bus.led_on;
      expected_pins.push_back(step_scan(w));
    end
  end

  // Receiver: stalls follow a rotating pattern that is reloaded whenever the stall phase wraps.
  logic [15:0] stall_pattern = 16'hFFFF;
  int          stall_phase = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (stall_phase == 63) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'hFFFF;
          1: stall_pattern = 16'($urandom) | 16'h0101;
          2: stall_pattern = 16'hCCCC;
          default: stall_pattern = 16'h8421;
        endcase
        stall_phase = 0;
      end else begin
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        stall_phase++;
      end
      result_bus.ready <= stall_pattern[0];
    end
  end

  // Result checker: every accepted word is matched against the oldest prediction.
  always @(posedge clk) begin
    pin_state_t got;
    pin_state_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got.enable_n = result_bus.level_enable_n;
      got.bank = result_bus.bank_select;
      got.addr = result_bus.column_address;
      got.empty = result_bus.frame_empty;
      if (expected_pins.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result enable_n=%h bank=%b addr=%0d empty=%b",
                 $time, got.enable_n, got.bank, got.addr, got.empty);
      end else begin
        want = expected_pins.pop_front();
        if (got.enable_n !== want.enable_n || got.bank !== want.bank ||
            got.addr !== want.addr || got.empty !== want.empty) begin
          fail_count++;
          $display("%0t: expected enable_n=%h bank=%b addr=%0d empty=%b", $time,
                   want.enable_n, want.bank, want.addr, want.empty);
          $display("%0t: actual   enable_n=%h bank=%b addr=%0d empty=%b", $time,
                   got.enable_n, got.bank, got.addr, got.empty);
        end
      end
    end
  end

  // Watchdog: gives up when no word moves for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
        || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("led_cube_multiplex_scanner verification failed");
        $finish;
      end
    end
  end

  // Waits until every queued word has been sent and answered, then lets the
  // pipeline settle.
  task automatic drain();
    while (pending_words.size() != 0 || item_bus.valid || expected_pins.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dwell(logic [lcms_pkg::DWELL_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    dwell_ticks = value;
  endtask

  // Random traffic: mostly ticks and writes that light LEDs, with occasional
  // clears, dark writes and unused actions. Unused actions are not counted.
  task automatic queue_scan_traffic(int count);
    int sent;
    int r;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, $urandom_range(0, 3),
                                        $urandom_range(0, 15), 1'($urandom_range(0, 1))));
      end else if (r < 88) begin
        pending_words.push_back(mk_word(lcms_pkg::ACT_WRITE, $urandom_range(0, 3),
                                        $urandom_range(0, 15), $urandom_range(0, 3) != 0));
      end else if (r < 93) begin
        pending_words.push_back(mk_word(lcms_pkg::ACT_CLEAR, $urandom_range(0, 3),
                                        $urandom_range(0, 15), 1'($urandom_range(0, 1))));
      end else if (r < 96) begin
        pending_words.push_back(mk_word(ACT_UNUSED, $urandom_range(0, 3), $urandom_range(0, 15),
                                        1'($urandom_range(0, 1))));
        sent--;
      end else begin
        pending_words.push_back(mk_word(lcms_pkg::ACT_WRITE, $urandom_range(0, 3),
                                        $urandom_range(0, 15), 1'b0));
      end
      sent++;
    end
  endtask

  initial begin
    logic [lcms_pkg::DWELL_W-1:0] dwell_plan[8];
    int                           count_plan[8];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    item_bus.valid = 1'b0;
    item_bus.action = lcms_pkg::ACT_TICK;
    item_bus.led_level = '0;
    item_bus.led_column = '0;
    item_bus.led_on = 1'b0;
    result_bus.ready = 1'b0;

    // Tracked state after reset.
    lit_map = '0;
    scan_pos = 0;
    dwell_cnt = 0;
    showing = 1'b0;
    active_lvl = lcms_pkg::LEVELS;
    pin_enable_n = '1;
    pin_bank = 1'b1;
    pin_addr = '0;
    dwell_ticks = lcms_pkg::DWELL_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset dwell: empty frame, unused action, the corner LEDs, a selected LED
    // turned dark mid-dwell, clear, and an upper-bank LED on a new level.
    pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, 0, 0, 1'b0));
    pending_words.push_back(mk_word(ACT_UNUSED, 3, 15, 1'b1));
    pending_words.push_back(mk_word(lcms_pkg::ACT_WRITE, 3, 15, 1'b1));
    pending_words.push_back(mk_word(lcms_pkg::ACT_WRITE, 0, 0, 1'b1));
    pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, 0, 0, 1'b0));
    pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, 3, 15, 1'b1));
    pending_words.push_back(mk_word(lcms_pkg::ACT_WRITE, 0, 0, 1'b0));
    pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, 0, 0, 1'b0));
    pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, 0, 0, 1'b0));
    pending_words.push_back(mk_word(lcms_pkg::ACT_CLEAR, 0, 0, 1'b0));
    pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, 0, 0, 1'b0));
    pending_words.push_back(mk_word(lcms_pkg::ACT_WRITE, 2, 9, 1'b1));
    pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, 0, 0, 1'b0));
    drain();

    // Zero dwell behaves as one: every tick moves on, wrapping across levels.
    write_dwell('0);
    pending_words.push_back(mk_word(lcms_pkg::ACT_WRITE, 1, 7, 1'b1));
    pending_words.push_back(mk_word(lcms_pkg::ACT_WRITE, 3, 8, 1'b1));
    pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, 0, 0, 1'b0));
    pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, 0, 0, 1'b0));
    pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, 0, 0, 1'b0));
    pending_words.push_back(mk_word(lcms_pkg::ACT_WRITE, 2, 9, 1'b0));
    pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, 0, 0, 1'b0));
    pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, 0, 0, 1'b0));
    pending_words.push_back(mk_word(ACT_UNUSED, 0, 0, 1'b0));
    pending_words.push_back(mk_word(lcms_pkg::ACT_CLEAR, 0, 0, 1'b0));
    pending_words.push_back(mk_word(lcms_pkg::ACT_TICK, 0, 0, 1'b0));
    drain();

    // Random phases over a spread of dwell settings, extremes included.
    dwell_plan = '{16'd1, 16'd2, 16'hFFFF, 16'd3, 16'd0, 16'($urandom_range(1, 6)),
                   lcms_pkg::DWELL_RESET, 16'($urandom_range(2, 10))};
    count_plan = '{250, 250, 120, 250, 250, 250, 120, 250};
    for (int ph = 0; ph < 8; ph++) begin
      write_dwell(dwell_plan[ph]);
      queue_scan_traffic(count_plan[ph]);
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_pins.size() == 0) begin
      $display("led_cube_multiplex_scanner verification clean");
    end else begin
      $display("led_cube_multiplex_scanner verification failed");
    end
    $finish;
  end

endmodule
